// File: hdl/tmc_pkg.sv
`default_nettype none

package tmc_pkg;

   // Fixed field widths of the channels and the configuration port
   localparam int SAMPLE_W   = 16;
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CHAN_SEL_W = 3;
   localparam int INDEX_W    = 10;
   localparam int POS_W      = 10;
   localparam int COUNT_W    = 16;
   localparam int FIELD_CHANNELS = 8;

   // Parameter defaults for the top level
   localparam int CHANNELS_DEF    = 8;
   localparam int DEPTH_DEF       = 1024;
   localparam int SAMPLE_BITS_DEF = 16;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DECIM   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLDOFF = 3'd5;

   // Run modes (code 3 acts as normal)
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_AUTO   = 2'd1;
   localparam logic [1:0] MODE_SINGLE = 2'd2;

   // Register reset values
   localparam logic [COUNT_W-1:0] DECIM_RST   = 16'd1;
   localparam logic [COUNT_W-1:0] TIMEOUT_RST = 16'd1024;
   localparam logic [COUNT_W-1:0] HOLDOFF_RST = 16'd1024;

   // Capture phases
   typedef enum logic [1:0] {
      PH_WAIT    = 2'd0,
      PH_READY   = 2'd1,
      PH_STORE   = 2'd2,
      PH_HOLDOFF = 2'd3
   } phase_type;

   // Per-item status from the controller
   typedef struct packed {
      phase_type        phase;
      logic             stopped;
      logic             stored_now;
      logic [POS_W-1:0] store_position;
      logic             frame_done;
      logic             read_ok;
   } status_type;

endpackage

`default_nettype wire

// File: hdl/tmc_ifs.sv
`default_nettype none

// Request channel: one sample tick or one read command per transfer
interface tmc_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   command;
   logic [tmc_pkg::CHAN_SEL_W-1:0]         read_channel;
   logic [tmc_pkg::INDEX_W-1:0]            read_index;
   logic signed [tmc_pkg::SAMPLE_W-1:0]    trigger_sample;
   logic signed [tmc_pkg::SAMPLE_W-1:0]    chan0_sample;
   logic signed [tmc_pkg::SAMPLE_W-1:0]    chan1_sample;
   logic signed [tmc_pkg::SAMPLE_W-1:0]    chan2_sample;
   logic signed [tmc_pkg::SAMPLE_W-1:0]    chan3_sample;
   logic signed [tmc_pkg::SAMPLE_W-1:0]    chan4_sample;
   logic signed [tmc_pkg::SAMPLE_W-1:0]    chan5_sample;
   logic signed [tmc_pkg::SAMPLE_W-1:0]    chan6_sample;
   logic signed [tmc_pkg::SAMPLE_W-1:0]    chan7_sample;

   modport source (
      output valid, command, read_channel, read_index, trigger_sample,
             chan0_sample, chan1_sample, chan2_sample, chan3_sample,
             chan4_sample, chan5_sample, chan6_sample, chan7_sample,
      input  ready
   );
   modport sink (
      input  valid, command, read_channel, read_index, trigger_sample,
             chan0_sample, chan1_sample, chan2_sample, chan3_sample,
             chan4_sample, chan5_sample, chan6_sample, chan7_sample,
      output ready
   );
endinterface

// Response channel: one result per request transfer
interface tmc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           phase;
   logic                                 stopped;
   logic                                 stored_now;
   logic [tmc_pkg::POS_W-1:0]            store_position;
   logic                                 frame_done;
   logic signed [tmc_pkg::SAMPLE_W-1:0]  read_data;

   modport source (
      output valid, phase, stopped, stored_now, store_position, frame_done, read_data,
      input  ready
   );
   modport sink (
      input  valid, phase, stopped, stored_now, store_position, frame_done, read_data,
      output ready
   );
endinterface

`default_nettype wire

// File: hdl/tmc_ctrl.sv
`default_nettype none

module tmc_ctrl #(
   parameter  int CHANNELS = tmc_pkg::CHANNELS_DEF,
   parameter  int DEPTH    = tmc_pkg::DEPTH_DEF,
   localparam int AW       = $clog2(DEPTH)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [tmc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tmc_pkg::CSR_W-1:0]           csr_wdata,
   input  wire logic                                item_go,
   input  wire logic                                command,
   input  wire logic [tmc_pkg::CHAN_SEL_W-1:0]      read_channel,
   input  wire logic [tmc_pkg::INDEX_W-1:0]         read_index,
   input  wire logic signed [tmc_pkg::SAMPLE_W-1:0] trigger_sample,
   output tmc_pkg::status_type                      status,
   output logic [AW-1:0]                            wr_addr
);

   localparam int CW = tmc_pkg::COUNT_W;

   // Configuration registers
   logic signed [tmc_pkg::SAMPLE_W-1:0] level_ff;
   logic                                slope_ff;
   logic [1:0]                          mode_ff;
   logic [CW-1:0]                       decim_ff;
   logic [CW-1:0]                       tmo_ff;
   logic [CW-1:0]                       hold_ff;

   // Capture state
   tmc_pkg::phase_type phase_ff, phase_in;
   logic               stop_ff, stop_in;
   logic [CW-1:0]      auto_ff, auto_in;
   logic [CW-1:0]      skip_ff, skip_in;
   logic [AW-1:0]      wp_ff, wp_in;
   logic [CW-1:0]      hcnt_ff, hcnt_in;
   logic [AW:0]        fill_ff, fill_in;

   logic               arm;
   logic               fire;
   logic               stored;
   logic               done;
   logic [AW:0]        wp_inc;

   // Trigger compare against the level for the selected slope
   always_comb begin
      if (!slope_ff) begin
         arm  = trigger_sample <  level_ff;
         fire = trigger_sample >= level_ff;
      end else begin
         arm  = trigger_sample >  level_ff;
         fire = trigger_sample <= level_ff;
      end
   end

   // Phase walk: wait, ready, store, holdoff in order, falling through
   always_comb begin
      phase_in = phase_ff;
      stop_in  = stop_ff;
      auto_in  = auto_ff;
      skip_in  = skip_ff;
      wp_in    = wp_ff;
      hcnt_in  = hcnt_ff;
      fill_in  = fill_ff;
      stored   = 1'b0;
      done     = 1'b0;
      wp_inc   = {1'b0, wp_ff} + 1'b1;
      if (!command) begin
         if (phase_in == tmc_pkg::PH_WAIT && !stop_in) begin
            if (mode_ff == tmc_pkg::MODE_AUTO) begin
               auto_in = auto_in + 1'b1;
               if (auto_in == tmo_ff) begin
                  phase_in = tmc_pkg::PH_STORE;
                  auto_in  = '0;
               end
            end
            if (arm) begin
               phase_in = tmc_pkg::PH_READY;
            end
         end
         if (phase_in == tmc_pkg::PH_READY) begin
            if (mode_ff == tmc_pkg::MODE_AUTO) begin
               auto_in = auto_in + 1'b1;
               if (auto_in == tmo_ff) begin
                  phase_in = tmc_pkg::PH_STORE;
                  auto_in  = '0;
               end
            end
            if (fire) begin
               phase_in = tmc_pkg::PH_STORE;
               auto_in  = '0;
            end
         end
         if (phase_in == tmc_pkg::PH_STORE) begin
            if (skip_in == '0) begin
               stored = 1'b1;
               wp_in  = AW'(wp_inc);
               if (wp_inc > fill_ff) begin
                  fill_in = wp_inc;
               end
               if (wp_inc == (AW+1)'(DEPTH)) begin
                  wp_in   = '0;
                  skip_in = '0;
                  done    = 1'b1;
                  if (mode_ff != tmc_pkg::MODE_SINGLE) begin
                     phase_in = tmc_pkg::PH_HOLDOFF;
                     hcnt_in  = '0;
                  end else begin
                     stop_in  = 1'b1;
                     phase_in = tmc_pkg::PH_WAIT;
                  end
               end
            end
            skip_in = skip_in + 1'b1;
            if (skip_in >= decim_ff) begin
               skip_in = '0;
            end
         end
         if (phase_in == tmc_pkg::PH_HOLDOFF) begin
            hcnt_in = hcnt_in + 1'b1;
            if (hcnt_in == hold_ff) begin
               phase_in = tmc_pkg::PH_WAIT;
            end
         end
      end
   end

   // Status for this transfer; reads check range and the filled span
   always_comb begin
      status.phase          = phase_in;
      status.stopped        = stop_in;
      status.stored_now     = stored;
      status.store_position = stored ? tmc_pkg::POS_W'(wp_ff) : '0;
      status.frame_done     = done;
      status.read_ok        = command
                              && (32'(read_channel) < 32'(CHANNELS))
                              && (32'(read_index) < 32'(DEPTH))
                              && (32'(read_index) < 32'(fill_ff));
   end

   assign wr_addr = wp_ff;

   // Configuration and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         slope_ff <= 1'b0;
         mode_ff  <= tmc_pkg::MODE_AUTO;
         decim_ff <= tmc_pkg::DECIM_RST;
         tmo_ff   <= tmc_pkg::TIMEOUT_RST;
         hold_ff  <= tmc_pkg::HOLDOFF_RST;
         phase_ff <= tmc_pkg::PH_WAIT;
         stop_ff  <= 1'b0;
         auto_ff  <= '0;
         skip_ff  <= '0;
         wp_ff    <= '0;
         hcnt_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         if (item_go) begin
            phase_ff <= phase_in;
            auto_ff  <= auto_in;
            skip_ff  <= skip_in;
            wp_ff    <= wp_in;
            hcnt_ff  <= hcnt_in;
            fill_ff  <= fill_in;
         end
         // A run mode write clears the stop flag
         if (csr_we && csr_index == tmc_pkg::CSR_MODE) begin
            stop_ff <= 1'b0;
         end else if (item_go) begin
            stop_ff <= stop_in;
         end
         if (csr_we) begin
            case (csr_index)
               tmc_pkg::CSR_LEVEL:   level_ff <= csr_wdata;
               tmc_pkg::CSR_SLOPE:   slope_ff <= csr_wdata[0];
               tmc_pkg::CSR_MODE:    mode_ff  <= csr_wdata[1:0];
               tmc_pkg::CSR_DECIM:   decim_ff <= csr_wdata;
               tmc_pkg::CSR_TIMEOUT: tmo_ff   <= csr_wdata;
               tmc_pkg::CSR_HOLDOFF: hold_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Filled span never passes the buffer depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (AW+1)'(DEPTH))
      else $error("fill count beyond depth");

   // A completed frame restarts the write position
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (item_go && status.frame_done) |=> (wp_ff == '0))
      else $error("write position not cleared after frame");

   // Stop only comes from a single shot frame
   a_stop_single: assert property (@(posedge clock) disable iff (reset)
      $rose(stop_ff) |-> (mode_ff == tmc_pkg::MODE_SINGLE))
      else $error("stop set outside single mode");

endmodule

`default_nettype wire

// File: hdl/tmc_lane.sv
`default_nettype none

module tmc_lane #(
   parameter  int DEPTH      = tmc_pkg::DEPTH_DEF,
   parameter  int STORE_BITS = tmc_pkg::SAMPLE_W,
   localparam int AW         = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  we,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire logic [STORE_BITS-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [AW-1:0]         rd_addr,
   output logic [STORE_BITS-1:0]      rd_data
);

   // One channel's capture buffer, registered read
   logic [STORE_BITS-1:0] mem [DEPTH];
   logic [STORE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/tmc_merge.sv
`default_nettype none

module tmc_merge #(
   parameter int CHANNELS   = tmc_pkg::CHANNELS_DEF,
   parameter int STORE_BITS = tmc_pkg::SAMPLE_W
) (
   input  wire logic [STORE_BITS-1:0]             lane_data [CHANNELS],
   input  wire logic [tmc_pkg::CHAN_SEL_W-1:0]    sel,
   input  wire logic                              ok,
   output logic signed [tmc_pkg::SAMPLE_W-1:0]    read_data
);

   localparam int SW = tmc_pkg::SAMPLE_W;
   localparam int SELW = tmc_pkg::CHAN_SEL_W;

   logic signed [STORE_BITS-1:0] pick;

   // Select the addressed lane; zero when the read missed
   always_comb begin
      pick = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (ok && sel == SELW'(c)) begin
            pick = lane_data[c];
         end
      end
      read_data = SW'(pick);
   end

endmodule

`default_nettype wire

// File: hdl/triggered_multichannel_capture_top.sv
// Triggered multichannel capture engine.
// req_ch carries one item per transfer: a sample tick (command 0) with a
// trigger sample and eight channel samples, or a read (command 1) of one
// stored entry by read_channel and read_index. rsp_ch returns exactly one
// result per request: phase, stop flag, store strobe and position, frame
// done, and read data. The csr_ port writes one register per cycle with
// csr_we high; write only while no request is in flight.
// Response valid is registered in the cycle after the request transfer; a
// new request is taken every cycle unless rsp_ch stalls. Each channel is
// a lane with its own buffer of DEPTH entries, one write and one read port,
// written at the capture position on a tick and read at the request index
// on a read, read data registered; the merge selects the addressed lane.
// Reset is synchronous and needs no clearing pass: a fill count marks the
// written span and reads beyond it return zero.
// When rsp_ch stalls the result holds in the output register and req_ch
// ready drops until it is taken; an incoming transfer is accepted in the
// same cycle the held result leaves.
`default_nettype none

module triggered_multichannel_capture_top #(
   parameter int CHANNELS    = tmc_pkg::CHANNELS_DEF,
   parameter int DEPTH       = tmc_pkg::DEPTH_DEF,
   parameter int SAMPLE_BITS = tmc_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   tmc_req_if.sink                             req_ch,
   tmc_rsp_if.source                           rsp_ch,
   input  wire logic                           csr_we,
   input  wire logic [tmc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tmc_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int STORE_BITS = (SAMPLE_BITS < tmc_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                  : tmc_pkg::SAMPLE_W;

   logic                               item_go;
   logic                               take;
   logic                               rsp_valid_ff, rsp_valid_in;
   tmc_pkg::status_type                status;
   tmc_pkg::status_type                status_ff;
   logic [tmc_pkg::CHAN_SEL_W-1:0]     sel_ff;
   logic [AW-1:0]                      wr_addr;
   logic signed [tmc_pkg::SAMPLE_W-1:0] samples [tmc_pkg::FIELD_CHANNELS];
   logic [STORE_BITS-1:0]              lane_data [CHANNELS];

   // Handshake: take a request whenever the output register is free or leaving
   assign take         = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = take;
   assign item_go      = req_ch.valid && take;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Controller: trigger phases, counters, fill span, configuration
   tmc_ctrl #(
      .CHANNELS (CHANNELS),
      .DEPTH    (DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .item_go        (item_go),
      .command        (req_ch.command),
      .read_channel   (req_ch.read_channel),
      .read_index     (req_ch.read_index),
      .trigger_sample (req_ch.trigger_sample),
      .status         (status),
      .wr_addr        (wr_addr)
   );

   // Channel samples as lane inputs
   assign samples[0] = req_ch.chan0_sample;
   assign samples[1] = req_ch.chan1_sample;
   assign samples[2] = req_ch.chan2_sample;
   assign samples[3] = req_ch.chan3_sample;
   assign samples[4] = req_ch.chan4_sample;
   assign samples[5] = req_ch.chan5_sample;
   assign samples[6] = req_ch.chan6_sample;
   assign samples[7] = req_ch.chan7_sample;

   // One buffer lane per channel
   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      tmc_lane #(
         .DEPTH      (DEPTH),
         .STORE_BITS (STORE_BITS)
      ) u_lane (
         .clock   (clock),
         .we      (item_go && status.stored_now),
         .wr_addr (wr_addr),
         .wr_data (STORE_BITS'(samples[c])),
         .rd_en   (item_go && req_ch.command),
         .rd_addr (AW'(req_ch.read_index)),
         .rd_data (lane_data[c])
      );
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_go) begin
         status_ff <= status;
         sel_ff    <= req_ch.read_channel;
      end
   end

   // Merge lane read data
   tmc_merge #(
      .CHANNELS   (CHANNELS),
      .STORE_BITS (STORE_BITS)
   ) u_merge (
      .lane_data (lane_data),
      .sel       (sel_ff),
      .ok        (status_ff.read_ok),
      .read_data (rsp_ch.read_data)
   );

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.phase          = status_ff.phase;
   assign rsp_ch.stopped        = status_ff.stopped;
   assign rsp_ch.stored_now     = status_ff.stored_now;
   assign rsp_ch.store_position = status_ff.store_position;
   assign rsp_ch.frame_done     = status_ff.frame_done;

   // Every request transfer yields a response next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      item_go |=> rsp_valid_ff)
      else $error("request transfer without response");

   // A held result blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request taken while result stalled");

   // Missed reads and ticks return zero data
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !status_ff.read_ok) |-> (rsp_ch.read_data == '0))
      else $error("nonzero read data without a hit");

endmodule

`default_nettype wire

// File: tb/capture_result_check.sv
module capture_result_check (
   input  logic                          clock,
   input  logic                          reset,
   tmc_req_if                            req_ch,
   tmc_rsp_if                            rsp_ch,
   input  logic                          csr_we,
   input  logic [tmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tmc_pkg::CSR_W-1:0]     csr_wdata,
   output int                            fail_count,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LANES      = tmc_pkg::CHANNELS_DEF;
   localparam int SPAN       = tmc_pkg::DEPTH_DEF;
   localparam int REPORT_MAX = 10;
   localparam int SW         = tmc_pkg::SAMPLE_W;
   localparam int CW         = tmc_pkg::COUNT_W;

   typedef struct {
      tmc_pkg::phase_type          phase;
      logic                        stopped;
      logic                        stored_now;
      logic [tmc_pkg::POS_W-1:0]   store_position;
      logic                        frame_done;
      logic signed [SW-1:0]        read_data;
   } capture_status_type;

   // Register copies
   logic signed [SW-1:0] trig_level;
   logic                 slope_fall;
   logic [1:0]           run_mode;
   logic [CW-1:0]        decim;
   logic [CW-1:0]        auto_limit;
   logic [CW-1:0]        holdoff_limit;

   // Engine state
   tmc_pkg::phase_type   phase_q;
   logic                 stop_q;
   logic [CW-1:0]        auto_ticks;
   logic [CW-1:0]        skip_cnt;
   logic [CW-1:0]        hold_cnt;
   int unsigned          wr_pos;
   logic signed [SW-1:0] lane_mem [LANES][SPAN];

   capture_status_type status_due[$];
   capture_status_type want;
   int                 seen;

   // Auto trigger counter; only runs in auto mode, wraps at 16 bits
   function automatic void bump_auto();
      if (run_mode == tmc_pkg::MODE_AUTO) begin
         auto_ticks = auto_ticks + 1'b1;
         if (auto_ticks == auto_limit) begin
            phase_q    = tmc_pkg::PH_STORE;
            auto_ticks = '0;
         end
      end
   endfunction

   // Advance the engine by one transfer and return the status it produces
   function automatic capture_status_type predict_capture(
      input logic                               cmd,
      input logic [tmc_pkg::CHAN_SEL_W-1:0]     rch,
      input logic [tmc_pkg::INDEX_W-1:0]        rix,
      input logic signed [SW-1:0]               trig,
      input logic [LANES*SW-1:0]                chans
   );
      capture_status_type st;
      logic               armed;
      logic               fired;
      st.phase          = tmc_pkg::PH_WAIT;
      st.stopped        = 1'b0;
      st.stored_now     = 1'b0;
      st.store_position = '0;
      st.frame_done     = 1'b0;
      st.read_data      = '0;
      if (cmd) begin
         // read leaves the engine untouched; every 3/10-bit address is in range
         st.read_data = lane_mem[rch][rix];
      end else begin
         armed = slope_fall ? (trig > trig_level) : (trig < trig_level);
         fired = slope_fall ? (trig <= trig_level) : (trig >= trig_level);
         if (phase_q == tmc_pkg::PH_WAIT && !stop_q) begin
            bump_auto();
            if (armed) phase_q = tmc_pkg::PH_READY;
         end
         if (phase_q == tmc_pkg::PH_READY) begin
            bump_auto();
            if (fired) begin
               phase_q    = tmc_pkg::PH_STORE;
               auto_ticks = '0;
            end
         end
         if (phase_q == tmc_pkg::PH_STORE) begin
            if (skip_cnt == '0) begin
               for (int c = 0; c < LANES; c++)
                  lane_mem[c][wr_pos] = chans[c*SW +: SW];
               st.stored_now     = 1'b1;
               st.store_position = tmc_pkg::POS_W'(wr_pos);
               wr_pos++;
               if (wr_pos >= SPAN) begin
                  wr_pos        = 0;
                  skip_cnt      = '0;
                  st.frame_done = 1'b1;
                  if (run_mode != tmc_pkg::MODE_SINGLE) begin
                     phase_q  = tmc_pkg::PH_HOLDOFF;
                     hold_cnt = '0;
                  end else begin
                     stop_q  = 1'b1;
                     phase_q = tmc_pkg::PH_WAIT;
                  end
               end
            end
            // decimation of zero acts as one
            skip_cnt = skip_cnt + 1'b1;
            if (skip_cnt >= decim) skip_cnt = '0;
         end
         if (phase_q == tmc_pkg::PH_HOLDOFF) begin
            hold_cnt = hold_cnt + 1'b1;
            if (hold_cnt == holdoff_limit) phase_q = tmc_pkg::PH_WAIT;
         end
      end
      st.phase   = phase_q;
      st.stopped = stop_q;
      return st;
   endfunction

   // Compare outgoing transfers, track register writes, predict incoming transfers
   always @(posedge clock) begin
      if (reset) begin
         trig_level    = '0;
         slope_fall    = 1'b0;
         run_mode      = tmc_pkg::MODE_AUTO;
         decim         = tmc_pkg::DECIM_RST;
         auto_limit    = tmc_pkg::TIMEOUT_RST;
         holdoff_limit = tmc_pkg::HOLDOFF_RST;
         phase_q       = tmc_pkg::PH_WAIT;
         stop_q        = 1'b0;
         auto_ticks    = '0;
         skip_cnt      = '0;
         hold_cnt      = '0;
         wr_pos        = 0;
         for (int l = 0; l < LANES; l++)
            for (int i = 0; i < SPAN; i++)
               lane_mem[l][i] = '0;
         status_due.delete();
         fail_count = 0;
         pending    = 0;
         seen       = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen++;
            if (status_due.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("result %0d arrived with no request outstanding", seen);
            end else begin
               want = status_due.pop_front();
               if (rsp_ch.phase !== want.phase || rsp_ch.stopped !== want.stopped ||
                   rsp_ch.stored_now !== want.stored_now ||
                   rsp_ch.store_position !== want.store_position ||
                   rsp_ch.frame_done !== want.frame_done ||
                   rsp_ch.read_data !== want.read_data) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX)
                     $display({"result %0d mismatch: expected phase %0d stop %0b st %0b ",
                               "pos %0d done %0b data %0d, got phase %0d stop %0b st %0b ",
                               "pos %0d done %0b data %0d"},
                              seen, want.phase, want.stopped, want.stored_now,
                              want.store_position, want.frame_done, want.read_data,
                              rsp_ch.phase, rsp_ch.stopped, rsp_ch.stored_now,
                              rsp_ch.store_position, rsp_ch.frame_done, rsp_ch.read_data);
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               tmc_pkg::CSR_LEVEL:   trig_level = csr_wdata;
               tmc_pkg::CSR_SLOPE:   slope_fall = csr_wdata[0];
               tmc_pkg::CSR_MODE: begin
                  run_mode = csr_wdata[1:0];
                  stop_q   = 1'b0;
               end
               tmc_pkg::CSR_DECIM:   decim = csr_wdata;
               tmc_pkg::CSR_TIMEOUT: auto_limit = csr_wdata;
               tmc_pkg::CSR_HOLDOFF: holdoff_limit = csr_wdata;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            status_due.push_back(predict_capture(req_ch.command, req_ch.read_channel,
               req_ch.read_index, req_ch.trigger_sample,
               {req_ch.chan7_sample, req_ch.chan6_sample, req_ch.chan5_sample,
                req_ch.chan4_sample, req_ch.chan3_sample, req_ch.chan2_sample,
                req_ch.chan1_sample, req_ch.chan0_sample}));
         pending = status_due.size();
      end
   end

endmodule

// File: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic       CMD_TICK   = 1'b0;
   localparam logic       CMD_READ   = 1'b1;
   localparam logic       SLOPE_RISE = 1'b0;
   localparam logic       SLOPE_FALL = 1'b1;
   localparam logic [1:0] MODE_SPARE = 2'd3;   // unused code, acts as normal
   localparam int         ITEM_GOAL  = 1400;
   localparam int         LONG_STALL = 300;
   localparam int         CYCLE_CAP  = 600000;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_we;
   logic [tmc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [tmc_pkg::CSR_W-1:0]     csr_wdata;
   int                            fail_count;
   int                            pending;
   int                            sent;
   int                            cur_level;
   int unsigned                   cycle_count;
   bit                            gaps_on;
   bit                            rsp_idle_on;

   tmc_req_if req_ch ();
   tmc_rsp_if rsp_ch ();

   triggered_multichannel_capture_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   capture_result_check u_check (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Sample values biased toward the extremes
   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [127:0] rand_chans();
      logic [127:0] v;
      for (int i = 0; i < 8; i++) v[i*16 +: 16] = rand_sample();
      return v;
   endfunction

   // Trigger sample close to the current level so crossings happen often
   function automatic logic [15:0] near_level();
      int t;
      t = cur_level + int'($urandom_range(0, 100)) - 50;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      return 16'(t);
   endfunction

   // One request transfer, with an optional idle burst ahead of it
   task automatic send_item(input logic cmd, input logic [2:0] rch, input logic [9:0] rix,
                            input logic [15:0] trig, input logic [127:0] chans);
      int n;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 10);
         repeat (n) begin
            @(negedge clock);
            req_ch.valid = 1'b0;
         end
      end
      @(negedge clock);
      req_ch.command        = cmd;
      req_ch.read_channel   = rch;
      req_ch.read_index     = rix;
      req_ch.trigger_sample = trig;
      req_ch.chan0_sample   = chans[15:0];
      req_ch.chan1_sample   = chans[31:16];
      req_ch.chan2_sample   = chans[47:32];
      req_ch.chan3_sample   = chans[63:48];
      req_ch.chan4_sample   = chans[79:64];
      req_ch.chan5_sample   = chans[95:80];
      req_ch.chan6_sample   = chans[111:96];
      req_ch.chan7_sample   = chans[127:112];
      req_ch.valid          = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
   endtask

   // Random tick or read; ticks mostly hover around the trigger level
   task automatic send_mixed(input int read_pct);
      logic [15:0] trig;
      int          pick;
      if ($urandom_range(0, 99) < read_pct) begin
         send_item(CMD_READ, 3'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)),
                   16'($urandom), rand_chans());
      end else begin
         pick = $urandom_range(0, 9);
         if (pick < 7) trig = near_level();
         else if (pick < 9) trig = 16'($urandom);
         else trig = rand_sample();
         send_item(CMD_TICK, 3'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)),
                   trig, rand_chans());
      end
   endtask

   task automatic write_reg(input logic [tmc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tmc_pkg::CSR_W-1:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
   endtask

   // Drain the block, then rewrite every register
   task automatic apply_settings(input int level, input logic slope, input logic [1:0] mode,
                                 input int decim, input int timeout, input int holdoff);
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      write_reg(tmc_pkg::CSR_LEVEL, 16'(level));
      write_reg(tmc_pkg::CSR_SLOPE, {15'd0, slope});
      write_reg(tmc_pkg::CSR_MODE, {14'd0, mode});
      write_reg(tmc_pkg::CSR_DECIM, 16'(decim));
      write_reg(tmc_pkg::CSR_TIMEOUT, 16'(timeout));
      write_reg(tmc_pkg::CSR_HOLDOFF, 16'(holdoff));
      @(negedge clock);
      csr_we    = 1'b0;
      cur_level = level;
   endtask

   // Result side: random stall bursts, calm stretches, one long hold-off
   initial begin
      int  stall_left;
      int  calm_left;
      bit  long_done;
      stall_left = 0;
      calm_left  = 0;
      long_done  = 1'b0;
      rsp_ch.ready = 1'b1;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else if (!long_done && sent >= 700) begin
            long_done    = 1'b1;
            stall_left   = LONG_STALL - 1;
            rsp_ch.ready = 1'b0;
         end else if (calm_left > 0 || !rsp_idle_on) begin
            rsp_ch.ready = 1'b1;
            if (calm_left > 0) calm_left--;
         end else if ($urandom_range(0, 39) == 0) begin
            rsp_ch.ready = 1'b1;
            calm_left    = $urandom_range(30, 100);
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_ch.ready = 1'b0;
            stall_left   = $urandom_range(0, 9);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   // Cycle limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_CAP) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      int         len;
      int         k;
      logic [1:0] mode;
      bit         calm;
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      sent        = 0;
      cur_level   = 0;
      gaps_on     = 1'b1;
      rsp_idle_on = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.command        = CMD_TICK;
      req_ch.read_channel   = '0;
      req_ch.read_index     = '0;
      req_ch.trigger_sample = '0;
      req_ch.chan0_sample   = '0;
      req_ch.chan1_sample   = '0;
      req_ch.chan2_sample   = '0;
      req_ch.chan3_sample   = '0;
      req_ch.chan4_sample   = '0;
      req_ch.chan5_sample   = '0;
      req_ch.chan6_sample   = '0;
      req_ch.chan7_sample   = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed: empty-store reads, arming with double auto count, auto fire
      // from ready, extreme samples, read-back, decimation zero and three
      apply_settings(0, SLOPE_RISE, tmc_pkg::MODE_AUTO, 1, 3, 2);
      send_item(CMD_READ, 3'd0, 10'd0, 16'h0000, '0);
      send_item(CMD_READ, 3'd7, 10'd1023, 16'h0000, '0);
      send_item(CMD_TICK, 3'd0, 10'd0, 16'h8000, {8{16'h1234}});
      send_item(CMD_TICK, 3'd0, 10'd0, 16'hFFFF, {8{16'h7FFF}});
      send_item(CMD_TICK, 3'd0, 10'd0, 16'h7FFF, {8{16'h8000}});
      send_item(CMD_TICK, 3'd7, 10'd1023, 16'h0000,
                {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001,
                 16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF});
      send_item(CMD_READ, 3'd0, 10'd0, 16'h0000, '0);
      send_item(CMD_READ, 3'd7, 10'd1, 16'h0000, '0);
      send_item(CMD_READ, 3'd5, 10'd2, 16'h0000, '0);
      send_item(CMD_READ, 3'd3, 10'd1023, 16'h0000, '0);
      apply_settings(-5, SLOPE_FALL, tmc_pkg::MODE_NORMAL, 0, 2, 4);
      repeat (3) send_item(CMD_TICK, 3'd0, 10'd0, near_level(), rand_chans());
      apply_settings(100, SLOPE_FALL, tmc_pkg::MODE_NORMAL, 3, 2, 4);
      repeat (6) send_item(CMD_TICK, 3'd0, 10'd0, near_level(), rand_chans());
      send_item(CMD_READ, 3'd0, 10'd3, 16'h0000, '0);
      send_item(CMD_READ, 3'd2, 10'd4, 16'h0000, '0);

      // Register extremes, kept short and early in the frame
      apply_settings(-32768, SLOPE_FALL, tmc_pkg::MODE_SINGLE, 0, 0, 65535);
      repeat (30) send_mixed(20);
      apply_settings(32767, SLOPE_RISE, MODE_SPARE, 65535, 65535, 0);
      repeat (30) send_mixed(20);

      // Random phases with small counts so frames, holdoffs and stops recur
      k = 0;
      while (sent < ITEM_GOAL) begin
         calm        = (sent >= ITEM_GOAL * 85 / 100);
         gaps_on     = !calm && ($urandom_range(0, 3) != 0);
         rsp_idle_on = !calm;
         case (k % 5)
            0: mode = tmc_pkg::MODE_NORMAL;
            1: mode = tmc_pkg::MODE_AUTO;
            2: mode = tmc_pkg::MODE_SINGLE;
            3: mode = tmc_pkg::MODE_AUTO;
            default: mode = MODE_SPARE;
         endcase
         apply_settings(int'($urandom_range(0, 400)) - 200, 1'($urandom_range(0, 1)), mode,
                        ($urandom_range(0, 9) == 0) ? 2 : (($urandom_range(0, 5) == 0) ? 0 : 1),
                        ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 40),
                        $urandom_range(1, 40));
         len = $urandom_range(80, 250);
         repeat (len) send_mixed(8);
         k++;
      end

      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
